// File: src/symbol_label_majority_classifier_assert.svh
// Assertion macros for the symbol label majority classifier.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef SYMBOL_LABEL_MAJORITY_CLASSIFIER_ASSERT_SVH
`define SYMBOL_LABEL_MAJORITY_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define SLMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SLMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SLMC_ASSERT(lbl, prop, msg)
`define SLMC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/slmc_pkg.sv
// Shared constants for the symbol label majority classifier.
// No dependencies.
package slmc_pkg;

  localparam int SYM_W             = 8;
  localparam int NUM_SYMBOLS       = 1 << SYM_W;
  localparam int LABEL_W           = 3;
  localparam int NUM_LABELS_DEF    = 8;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int S_TDATA_W         = 16;
  localparam int M_TDATA_W         = 8;

  localparam logic OP_TRAIN   = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

endpackage

// File: src/slmc_argmax.sv
// Registered compare tree: picks the label with the highest count, lowest code on ties.
// Depends on slmc_pkg. Every node of the tree is registered.
module slmc_argmax
  import slmc_pkg::*;
#(
  parameter int NUM_LABELS  = NUM_LABELS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic [NUM_LABELS-1:0][COUNT_WIDTH-1:0] row_i,
  output logic [LABEL_W-1:0]                     best_label_o,
  output logic                                   best_nonzero_o
);

  localparam int LEVELS = $clog2(NUM_LABELS);
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = LEAVES - 1;
  localparam int TOTAL  = 2 * LEAVES - 1;

  logic [COUNT_WIDTH-1:0] node_cnt_q [NODES];
  logic [LEVELS-1:0]      node_idx_q [NODES];
  logic [COUNT_WIDTH-1:0] node_cnt_d [NODES];
  logic [LEVELS-1:0]      node_idx_d [NODES];
  logic [COUNT_WIDTH-1:0] all_cnt    [TOTAL];
  logic [LEVELS-1:0]      all_idx    [TOTAL];

  always_comb begin
    for (int n = 0; n < NODES; n++) begin
      all_cnt[n] = node_cnt_q[n];
      all_idx[n] = node_idx_q[n];
    end
    for (int i = 0; i < LEAVES; i++) begin
      all_idx[NODES + i] = LEVELS'(i);
      if (i < NUM_LABELS) begin
        all_cnt[NODES + i] = row_i[i];
      end else begin
        all_cnt[NODES + i] = '0;
      end
    end
  end

  // left child always holds the lower codes, so >= keeps the lowest on ties
  always_comb begin
    for (int n = 0; n < NODES; n++) begin
      if (all_cnt[2*n+1] >= all_cnt[2*n+2]) begin
        node_cnt_d[n] = all_cnt[2*n+1];
        node_idx_d[n] = all_idx[2*n+1];
      end else begin
        node_cnt_d[n] = all_cnt[2*n+2];
        node_idx_d[n] = all_idx[2*n+2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_cnt_q <= node_cnt_d;
    node_idx_q <= node_idx_d;
  end

  assign best_label_o   = LABEL_W'(node_idx_q[0]);
  assign best_nonzero_o = (node_cnt_q[0] != '0);

endmodule

// File: src/symbol_label_majority_classifier.sv
// Top level of the symbol label majority classifier.
// Depends on slmc_pkg, slmc_argmax and symbol_label_majority_classifier_assert.svh.
//
// Usage:
//   Input stream (s_axis): tuser = op (0 train, 1 predict), tdata = symbol, label.
//   A train transfer adds one to the saturating counter of its symbol and label
//   and gives no result. A predict transfer gives one result on m_axis:
//   the label with the highest count for the symbol (lowest code on ties) and
//   a known flag; an untrained symbol returns default_label with known = 0.
//   Labels at or beyond NUM_LABELS are ignored on train.
//   cfg_we_i / cfg_wdata_i write default_label; write only while idle.
// Timing:
//   Counts live in one 256-row memory, one row of all label counts per symbol,
//   read through a registered read port. Train: read, then increment and write
//   back. Predict: read, then the registered compare tree. One item is in flight
//   at a time: the next transfer is taken only once a train has written back or
//   a predict has loaded its result into the output register.
// Reset: clears all row valid flags (every count reads zero), default_label = 0.
// Stall: a result waits in the output register; the next item is accepted,
//   but a predict does not complete until the pending result is taken.
module symbol_label_majority_classifier
  import slmc_pkg::*;
#(
  parameter int NUM_LABELS  = NUM_LABELS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] symbol, [10:8] label, rest zero
  input  logic                 s_axis_tuser,   // [0] op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [2:0] predicted_label, [3] symbol_known
  input  logic                 cfg_we_i,
  input  logic [LABEL_W-1:0]   cfg_wdata_i     // default_label
);

`include "symbol_label_majority_classifier_assert.svh"

  localparam int LEVELS = $clog2(NUM_LABELS);
  localparam int WAIT_W = $clog2(LEVELS + 1);
  localparam int LIW    = $clog2(NUM_LABELS);

  typedef logic [NUM_LABELS-1:0][COUNT_WIDTH-1:0] row_t;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_e;

  state_e               state_q;
  logic [WAIT_W-1:0]    wait_q;
  logic                 op_q;
  logic [SYM_W-1:0]     sym_q;
  logic [LABEL_W-1:0]   label_q;
  logic [LABEL_W-1:0]   default_q;
  logic                 out_valid_q;
  logic [LABEL_W-1:0]   out_label_q;
  logic                 out_known_q;

  row_t                 mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] row_vld_q;
  row_t                 rdata_q;
  logic                 rvld_q;
  row_t                 row_eff;
  row_t                 row_d;
  logic [LIW-1:0]       lab_idx;
  logic                 lab_ok;

  logic                 accept;
  logic                 mem_we;
  logic                 pred_done;
  logic [LABEL_W-1:0]   best_label;
  logic                 best_nonzero;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign row_eff = rvld_q ? rdata_q : '0;
  assign lab_idx = LIW'(label_q);
  assign lab_ok  = int'(label_q) < NUM_LABELS;

  always_comb begin
    row_d = row_eff;
    if (row_eff[lab_idx] != '1) begin
      row_d[lab_idx] = row_eff[lab_idx] + 1'b1;
    end
  end

  assign mem_we    = (state_q == S_BUSY) && (op_q == OP_TRAIN) && lab_ok;
  assign pred_done = (state_q == S_BUSY) && (op_q == OP_PREDICT) &&
                     (wait_q == WAIT_W'(LEVELS)) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem[s_axis_tdata[SYM_W-1:0]];
    end
    if (mem_we) begin
      mem[sym_q] <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser;
      sym_q   <= s_axis_tdata[SYM_W-1:0];
      label_q <= s_axis_tdata[SYM_W+LABEL_W-1:SYM_W];
      rvld_q  <= row_vld_q[s_axis_tdata[SYM_W-1:0]];
    end
    if (pred_done) begin
      out_label_q <= best_nonzero ? best_label : default_q;
      out_known_q <= best_nonzero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= '0;
      default_q   <= '0;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        default_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        row_vld_q[sym_q] <= 1'b1;
      end
      if (pred_done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_BUSY;
            wait_q  <= '0;
          end
        end
        S_BUSY: begin
          if (op_q == OP_TRAIN || pred_done) begin
            state_q <= S_IDLE;
          end else if (wait_q != WAIT_W'(LEVELS)) begin
            wait_q <= wait_q + 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  slmc_argmax #(
    .NUM_LABELS  (NUM_LABELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_argmax (
    .clk_i          (clk_i),
    .row_i          (row_eff),
    .best_label_o   (best_label),
    .best_nonzero_o (best_nonzero)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W-LABEL_W-1)'(0), out_known_q, out_label_q};

  `SLMC_ASSERT(a_one_in_flight, accept |=> !s_axis_tready, "second item accepted while busy")
  `SLMC_ASSERT(a_no_rw_overlap, mem_we |-> !accept, "row write overlaps a new read")
  `SLMC_ASSERT(a_result_from_predict, $rose(out_valid_q) |-> $past(op_q == OP_PREDICT), "result without predict")
  `SLMC_ASSERT(a_known_label_range, (out_valid_q && out_known_q) |-> (int'(out_label_q) < NUM_LABELS), "known label out of range")

endmodule

// File: sim/tb_symbol_label_majority_classifier.sv
// Self-checking testbench for symbol_label_majority_classifier: drives train and predict
// transfers, predicts every vote from its own count table and checks each result.
// Depends on slmc_pkg and the classifier RTL.
module tb_symbol_label_majority_classifier;
  import slmc_pkg::*;

  localparam int NUM_LBL       = NUM_LABELS_DEF;
  localparam int COUNT_W       = COUNT_WIDTH_DEF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int STUCK_LIMIT   = 3000;
  localparam int HOT_N         = 12;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               known;
  } vote_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // [7:0] symbol, [10:8] label
  logic                 s_axis_tuser = 1'b0; // [0] op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // [2:0] predicted_label, [3] symbol_known
  logic                 cfg_we_i = 1'b0;
  logic [LABEL_W-1:0]   cfg_wdata_i = '0;

  logic [COUNT_W-1:0] label_tally [NUM_SYMBOLS][NUM_LBL];
  logic [LABEL_W-1:0] dflt_label;
  vote_t              vote_q [$];
  logic [SYM_W-1:0]   hot_syms [HOT_N];

  int unsigned errors = 0;
  int unsigned n_train = 0;
  int unsigned n_predict = 0;
  int unsigned n_checked = 0;
  int unsigned stuck_cycles = 0;
  int unsigned burst_left = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_stall_en = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_run = 0;
  bit          rx_busy = 1'b0;

  symbol_label_majority_classifier u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Count a trained pair, or queue the expected vote for a predict.
  task automatic count_or_vote(input logic op, input logic [SYM_W-1:0] sym,
                               input logic [LABEL_W-1:0] lab);
    vote_t              v;
    logic [COUNT_W-1:0] top;
    if (op == OP_TRAIN) begin
      n_train++;
      if (int'(lab) < NUM_LBL && label_tally[sym][lab] != COUNT_MAX) begin
        label_tally[sym][lab] = label_tally[sym][lab] + 1'b1;
      end
    end else begin
      n_predict++;
      top = '0;
      v.label = '0;
      for (int i = 0; i < NUM_LBL; i++) begin
        if (label_tally[sym][i] > top) begin
          top = label_tally[sym][i];
          v.label = LABEL_W'(i);
        end
      end
      v.known = (top != '0);
      if (!v.known) v.label = dflt_label;
      vote_q.insert(vote_q.size(), v);
    end
  endtask

  // Entered and left at a falling edge; tvalid stays high on return.
  task automatic send_item(input logic op, input logic [SYM_W-1:0] sym,
                           input logic [LABEL_W-1:0] lab);
    int unsigned gap;
    if (tx_idle_en && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= S_TDATA_W'({lab, sym});
    do @(posedge clk_i); while (!s_axis_tready);
    count_or_vote(op, sym, lab);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (vote_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_default_label(input logic [LABEL_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    dflt_label = value;
  endtask

  task automatic test_reset_state();
    send_item(OP_PREDICT, 8'h00, 3'd0);
    send_item(OP_PREDICT, 8'hFF, 3'd7);
    send_item(OP_PREDICT, 8'h43, 3'd5);
    wait_drained();
  endtask

  task automatic test_default_label();
    write_default_label(3'd7);
    send_item(OP_PREDICT, 8'h43, 3'd0);
    write_default_label(3'd0);
    send_item(OP_PREDICT, 8'h43, 3'd0);
    write_default_label(3'd7);
  endtask

  task automatic test_majority_and_ties();
    send_item(OP_TRAIN, 8'h00, 3'd7);
    send_item(OP_PREDICT, 8'h00, 3'd0);
    send_item(OP_TRAIN, 8'hFF, 3'd7);
    send_item(OP_TRAIN, 8'hFF, 3'd0);
    send_item(OP_PREDICT, 8'hFF, 3'd7);   // tie, lowest label wins
    send_item(OP_TRAIN, 8'hAA, 3'd3);
    send_item(OP_TRAIN, 8'hAA, 3'd6);
    send_item(OP_TRAIN, 8'hAA, 3'd3);
    send_item(OP_PREDICT, 8'hAA, 3'd6);
    send_item(OP_TRAIN, 8'h01, 3'd1);
    send_item(OP_TRAIN, 8'h01, 3'd2);
    send_item(OP_TRAIN, 8'h01, 3'd4);
    send_item(OP_TRAIN, 8'h01, 3'd4);
    send_item(OP_PREDICT, 8'h01, 3'd0);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    hold_req++;
    for (int i = 0; i < 12; i++) begin
      send_item(OP_PREDICT, (i % 2 == 0) ? 8'hAA : 8'h01, 3'($urandom));
    end
    wait_drained();
  endtask

  task automatic run_random_items(input int unsigned n_items);
    logic               op;
    logic [SYM_W-1:0]   sym;
    logic [LABEL_W-1:0] lab;
    for (int unsigned i = 0; i < n_items; i++) begin
      sym = ($urandom_range(0, 99) < 85) ? hot_syms[$urandom_range(0, HOT_N - 1)]
                                         : SYM_W'($urandom);
      op  = ($urandom_range(0, 99) < 55) ? OP_TRAIN : OP_PREDICT;
      lab = ($urandom_range(0, 1) != 0) ? (sym[2:0] ^ sym[5:3]) : LABEL_W'($urandom);
      send_item(op, sym, lab);
    end
  endtask

  task automatic test_random_traffic();
    foreach (hot_syms[i]) hot_syms[i] = SYM_W'($urandom);
    write_default_label(3'd3);
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    run_random_items(200);
    write_default_label(3'd0);
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    run_random_items(200);
    write_default_label(LABEL_W'($urandom));
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    run_random_items(200);
    wait_drained();
  endtask

  // Receiver: random ready runs, or a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_en) begin
      if (rx_run == 0) begin
        rx_busy = ~rx_busy;
        rx_run  = rx_busy ? $urandom_range(1, 5) : $urandom_range(1, 10);
      end
      rx_run--;
      m_axis_tready <= !rx_busy;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_votes
    vote_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (vote_q.size() == 0) begin
        $error("result transfer with no vote pending: tdata=%h", m_axis_tdata);
        errors++;
      end else begin
        want = vote_q.pop_front();
        n_checked++;
        if (m_axis_tdata[2:0] !== want.label) begin
          $error("predicted_label: expected %0d, actual %0d", want.label, m_axis_tdata[2:0]);
          errors++;
        end
        if (m_axis_tdata[3] !== want.known) begin
          $error("symbol_known: expected %0d, actual %0d", want.known, m_axis_tdata[3]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("tb_symbol_label_majority_classifier: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    foreach (label_tally[s, l]) label_tally[s][l] = '0;
    dflt_label = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_default_label();
    test_majority_and_ties();
    test_output_backpressure();
    test_random_traffic();
    $display("covered %0d transfers in (%0d train, %0d predict) and %0d checked votes,",
             n_train + n_predict, n_train, n_predict, n_checked);
    $display("with default label changes, ties, unseen symbols and output hold-off");
    if (errors == 0) begin
      $display("tb_symbol_label_majority_classifier: PASS");
    end else begin
      $display("tb_symbol_label_majority_classifier: FAIL");
    end
    $finish;
  end

endmodule
